// ===== rtl/rmed_pkg.sv =====
// Package for the running median block: sizes, status codes, FSM states.
// No dependencies.
`default_nettype none
package rmed_pkg;
  localparam int Capacity = 1024;
  localparam int AddrW = $clog2(Capacity);
  localparam int CountW = $clog2(Capacity + 1);

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_ABSENT = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_MED_A,
    S_MED_B,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/running_median_add_remove_top.sv =====
// Running median top level: sorted store in one synchronous RAM plus sequencer.
// Depends on rmed_pkg.
//
// Values are held in ascending order in a 1024-entry RAM. An item takes a
// binary search (one RAM read per step, up to 11 steps, then a closing check
// and, on a remove, one more read to check the hit), then a shift of the
// entries above the insert or remove point with one RAM read and write per moved
// entry, then one or two reads for the median. An add on a full set skips the
// shift and the median reads. One item is handled at a time. The result sits in
// an output register; the next item is accepted the cycle after it has been taken.
`default_nettype none
module running_median_add_remove_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_cmd,
  input  wire logic signed [31:0] in_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic signed [32:0] out_median_x2,
  output logic [10:0]      out_count
);
  localparam int AW = rmed_pkg::AddrW;
  localparam int CW = rmed_pkg::CountW;

  logic signed [31:0] mem [rmed_pkg::Capacity];
  logic signed [31:0] rdata_r;
  logic [AW-1:0] raddr;
  logic we;
  logic [AW-1:0] waddr;
  logic signed [31:0] wdata;

  rmed_pkg::state_t state_r, state_nxt;
  logic cmd_r, cmd_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic phase_r, phase_nxt;
  logic signed [31:0] mida_r, mida_nxt;
  logic [1:0] st_r, st_nxt;
  logic signed [32:0] med_r, med_nxt;
  logic ov_r, ov_nxt;
  logic [CW-1:0] mid;
  logic [CW-1:0] half;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign half = cnt_r >> 1;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    val_nxt = val_r;
    cnt_nxt = cnt_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    pos_nxt = pos_r;
    phase_nxt = phase_r;
    mida_nxt = mida_r;
    st_nxt = st_r;
    med_nxt = med_r;
    ov_nxt = ov_r;
    raddr = mid[AW-1:0];
    we = 1'b0;
    waddr = pos_r[AW-1:0];
    wdata = val_r;
    in_ready = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      rmed_pkg::S_IDLE: begin
        in_ready = !ov_r;
        if (in_valid && !ov_r) begin
          cmd_nxt = in_cmd;
          val_nxt = in_value;
          lo_nxt = '0;
          hi_nxt = cnt_r;
          phase_nxt = 1'b0;
          state_nxt = rmed_pkg::S_SEARCH;
        end
      end
      rmed_pkg::S_SEARCH: begin
        // upper bound search; phase 0 issues read at mid, phase 1 compares
        if (!phase_r) begin
          if (lo_r == hi_r) begin
            if (!cmd_r) begin
              if (cnt_r == CW'(rmed_pkg::Capacity)) begin
                st_nxt = rmed_pkg::ST_FULL;
                state_nxt = rmed_pkg::S_OUT;
              end else begin
                pos_nxt = cnt_r;
                state_nxt = rmed_pkg::S_SHIFT;
              end
            end else if (lo_r == '0) begin
              st_nxt = rmed_pkg::ST_ABSENT;
              state_nxt = rmed_pkg::S_OUT;
            end else begin
              raddr = AW'(lo_r - 1'b1);
              phase_nxt = 1'b1;
            end
          end else phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          if (lo_r == hi_r) begin
            if (rdata_r != val_r) begin
              st_nxt = rmed_pkg::ST_ABSENT;
              state_nxt = rmed_pkg::S_OUT;
            end else begin
              pos_nxt = lo_r;
              state_nxt = rmed_pkg::S_SHIFT;
            end
          end else if (rdata_r <= val_r) lo_nxt = mid + 1'b1;
          else hi_nxt = mid;
        end
      end
      rmed_pkg::S_SHIFT: begin
        if (!cmd_r) begin
          // insert: move entries down from the top, then place value at lo
          raddr = AW'(pos_r - 1'b1);
          if (pos_r == lo_r) begin
            waddr = lo_r[AW-1:0];
            wdata = val_r;
            we = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
            phase_nxt = 1'b0;
            state_nxt = rmed_pkg::S_MED_A;
          end else if (!phase_r) phase_nxt = 1'b1;
          else begin
            we = 1'b1;
            wdata = rdata_r;
            pos_nxt = pos_r - 1'b1;
            phase_nxt = 1'b0;
          end
        end else begin
          // remove: pos runs from p upward, copying entry pos into pos-1
          raddr = pos_r[AW-1:0];
          waddr = AW'(pos_r - 1'b1);
          if (pos_r == cnt_r) begin
            cnt_nxt = cnt_r - 1'b1;
            phase_nxt = 1'b0;
            if (cnt_r == CW'(1)) begin
              st_nxt = rmed_pkg::ST_EMPTY;
              state_nxt = rmed_pkg::S_OUT;
            end else state_nxt = rmed_pkg::S_MED_A;
          end else if (!phase_r) phase_nxt = 1'b1;
          else begin
            we = 1'b1;
            wdata = rdata_r;
            pos_nxt = pos_r + 1'b1;
            phase_nxt = 1'b0;
          end
        end
      end
      rmed_pkg::S_MED_A: begin
        raddr = half[AW-1:0];
        if (!phase_r) phase_nxt = 1'b1;
        else begin
          mida_nxt = rdata_r;
          phase_nxt = 1'b0;
          if (cnt_r[0]) begin
            med_nxt = {rdata_r, 1'b0};
            st_nxt = rmed_pkg::ST_OK;
            state_nxt = rmed_pkg::S_OUT;
          end else state_nxt = rmed_pkg::S_MED_B;
        end
      end
      rmed_pkg::S_MED_B: begin
        raddr = AW'(half - 1'b1);
        if (!phase_r) phase_nxt = 1'b1;
        else begin
          med_nxt = 33'(mida_r) + 33'(rdata_r);
          st_nxt = rmed_pkg::ST_OK;
          phase_nxt = 1'b0;
          state_nxt = rmed_pkg::S_OUT;
        end
      end
      rmed_pkg::S_OUT: begin
        if (st_r != rmed_pkg::ST_OK) med_nxt = '0;
        ov_nxt = 1'b1;
        state_nxt = rmed_pkg::S_IDLE;
      end
      default: state_nxt = rmed_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmed_pkg::S_IDLE;
      cnt_r <= '0;
      ov_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
      phase_r <= phase_nxt;
    end
    cmd_r <= cmd_nxt;
    val_r <= val_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    pos_r <= pos_nxt;
    mida_r <= mida_nxt;
    st_r <= st_nxt;
    med_r <= med_nxt;
  end

  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_median_x2 = med_r;
  assign out_count = cnt_r;

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(rmed_pkg::Capacity)) else $error("count above capacity");
  a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rmed_pkg::S_SEARCH |-> lo_r <= hi_r) else $error("search bounds crossed");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> state_r != rmed_pkg::S_SEARCH && state_r != rmed_pkg::S_SHIFT)
    else $error("working while result pending");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !$past(ov_r) |-> ($past(cnt_r) == cnt_r) || ($past(cnt_r) + 1'b1 == cnt_r)
      || (cnt_r + 1'b1 == $past(cnt_r))) else $error("count moved by more than one");
endmodule
`default_nettype wire
